FILE: sv/cacr_pkg.sv
package cacr_pkg;

  // Alphabet capacity and derived widths
  localparam int ALPHABET_MAX  = 128;
  localparam int IDX_W         = $clog2(ALPHABET_MAX);
  localparam int CNT_W         = $clog2(ALPHABET_MAX + 1);

  // Default character set loaded at reset
  localparam int DEFAULT_COUNT = 95;
  localparam int DEF_LOAD      = (ALPHABET_MAX < DEFAULT_COUNT) ? ALPHABET_MAX : DEFAULT_COUNT;
  localparam int INIT_W        = (DEF_LOAD > 1) ? $clog2(DEF_LOAD) : 1;

  localparam logic [DEFAULT_COUNT*8-1:0] DEFAULT_STR = {
    8'h20, 8'h0A, 8'h0D, 8'h09,
    "abcdefghijklmnopqrstuvwxyz",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    "[]{}",
    "1234567890",
    "!@#$%^&*()_+-=,./<>?:;",
    8'h22, 8'h5C, 8'h7E
  };

  // Rotation register and remainder sequencer
  localparam int ROT_W         = 8;
  localparam int STEP_W        = $clog2(ROT_W);
  localparam logic [ROT_W-1:0] ROTATION_RESET = 8'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd1;

  // Item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_XFORM  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } cacr_in_t;

  typedef struct packed {
    logic [7:0] value_out;
    logic [1:0] status;
    logic [7:0] alphabet_size;
  } cacr_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              init_we;
    logic [INIT_W-1:0] init_idx;
    logic              accept;
    logic              mod_step;
    logic [STEP_W-1:0] step_idx;
    logic              look;
    logic              fetch;
    logic              out_load;
  } cacr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic lookup;
  } cacr_stat_t;

  // i-th character of the default set
  function automatic logic [7:0] default_char(input int i);
    return DEFAULT_STR[(DEFAULT_COUNT - 1 - i) * 8 +: 8];
  endfunction

  // Membership marks of the loaded part of the default set
  function automatic logic [255:0] default_mask();
    logic [255:0] m;
    m = '0;
    for (int i = 0; i < DEF_LOAD; i++) begin
      m[default_char(i)] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [255:0] DEFAULT_MASK = default_mask();

endpackage

FILE: sv/cacr_ctrl.sv
module cacr_ctrl
  import cacr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  cacr_stat_t stat,
  output cacr_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MOD   = 6'b000100,
    S_LOOK  = 6'b001000,
    S_FETCH = 6'b010000,
    S_RES   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [INIT_W-1:0] init_idx, init_idx_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic out_valid_next;
  logic accept;
  logic slot_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next    = state;
    init_idx_next = init_idx;
    step_cnt_next = step_cnt;
    cmd           = '0;
    cmd.init_idx  = init_idx;
    cmd.step_idx  = step_cnt;
    cmd.accept    = accept;
    case (state)
      S_INIT: begin
        cmd.init_we   = 1'b1;
        init_idx_next = init_idx + 1'b1;
        if (init_idx == INIT_W'(DEF_LOAD - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        step_cnt_next = '0;
        if (accept) begin
          state_next = stat.lookup ? S_MOD : S_RES;
        end
      end
      S_MOD: begin
        cmd.mod_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == STEP_W'(ROT_W - 1)) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_idx  <= '0;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      init_idx  <= init_idx_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: sv/cacr_datapath.sv
module cacr_datapath
  import cacr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cacr_cmd_t            cmd,
  output cacr_stat_t           stat,
  input  cacr_in_t             in_data,
  output cacr_out_t            out_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  // Alphabet storage
  logic [7:0]       chars_mem [ALPHABET_MAX];
  logic [IDX_W-1:0] pos_mem   [256];
  logic [255:0]     char_valid;
  logic [CNT_W-1:0] count;
  logic             dup;

  // Configuration
  logic [ROT_W-1:0] rotation;
  logic             direction;

  // Item and result registers
  logic [IDX_W-1:0] pos_rdata;
  logic [7:0]       chars_rdata;
  logic [CNT_W-1:0] rem, rem_next;
  logic [7:0]       res_value;
  logic [1:0]       res_status;

  logic             full;
  logic [CNT_W:0]   n_ext;
  logic [CNT_W:0]   shifted;
  logic             rot_bit;
  logic [CNT_W:0]   idx_raw;
  logic [CNT_W:0]   idx_mod;
  logic [IDX_W-1:0] rd_idx;

  logic             chars_we;
  logic [IDX_W-1:0] chars_waddr;
  logic [7:0]       chars_wdata;
  logic             pos_we;
  logic [7:0]       pos_waddr;
  logic [IDX_W-1:0] pos_wdata;

  assign full  = (count >= CNT_W'(ALPHABET_MAX));
  assign n_ext = {1'b0, count};

  assign stat.lookup = (in_data.kind == KIND_XFORM) && !dup && (count != '0) &&
                       char_valid[in_data.value];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation  <= ROTATION_RESET;
      direction <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROTATION:  rotation  <= cfg_data;
        CFG_DIRECTION: direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Memory write ports: reset sweep or append
  always_comb begin
    chars_we    = 1'b0;
    chars_waddr = IDX_W'(count);
    chars_wdata = in_data.value;
    pos_we      = 1'b0;
    pos_waddr   = in_data.value;
    pos_wdata   = IDX_W'(count);
    if (cmd.init_we) begin
      chars_we    = 1'b1;
      chars_waddr = IDX_W'(cmd.init_idx);
      chars_wdata = default_char(int'(cmd.init_idx));
      pos_we      = 1'b1;
      pos_waddr   = default_char(int'(cmd.init_idx));
      pos_wdata   = IDX_W'(cmd.init_idx);
    end else if (cmd.accept && (in_data.kind == KIND_APPEND) && !full) begin
      chars_we = 1'b1;
      pos_we   = !char_valid[in_data.value];
    end
  end

  // Rotation remainder, one bit of the rotation per step, MSB first
  assign rot_bit = rotation[STEP_W'(ROT_W - 1) - cmd.step_idx];
  assign shifted = {rem, rot_bit};
  always_comb begin
    if (shifted >= n_ext) begin
      rem_next = CNT_W'(shifted - n_ext);
    end else begin
      rem_next = CNT_W'(shifted);
    end
  end

  // Rotated index: one add (an add and a subtract in reverse direction) and one conditional subtract
  always_comb begin
    if (direction) begin
      idx_raw = (CNT_W+1)'(pos_rdata) + n_ext - (CNT_W+1)'(rem);
    end else begin
      idx_raw = (CNT_W+1)'(pos_rdata) + (CNT_W+1)'(rem);
    end
    if (idx_raw >= n_ext) begin
      idx_mod = idx_raw - n_ext;
    end else begin
      idx_mod = idx_raw;
    end
  end
  assign rd_idx = idx_mod[IDX_W-1:0];

  // Memories
  always_ff @(posedge clk) begin
    if (chars_we) begin
      chars_mem[chars_waddr] <= chars_wdata;
    end
    if (cmd.look) begin
      chars_rdata <= chars_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (cmd.accept) begin
      pos_rdata <= pos_mem[in_data.value];
    end
  end

  // Alphabet control state
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= DEFAULT_MASK;
      count      <= CNT_W'(DEF_LOAD);
      dup        <= 1'b0;
    end else if (cmd.accept) begin
      case (in_data.kind)
        KIND_CLEAR: begin
          char_valid <= '0;
          count      <= '0;
          dup        <= 1'b0;
        end
        KIND_APPEND: begin
          if (!full) begin
            count <= count + 1'b1;
            if (char_valid[in_data.value]) begin
              dup <= 1'b1;
            end else begin
              char_valid[in_data.value] <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result selection
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rem        <= '0;
      res_value  <= in_data.value;
      res_status <= ST_DONE;
      case (in_data.kind)
        KIND_APPEND: begin
          if (full) begin
            res_status <= ST_FULL;
          end
        end
        KIND_XFORM: begin
          if (dup) begin
            res_value  <= 8'd0;
            res_status <= ST_DUP;
          end else if (!stat.lookup) begin
            res_status <= ST_MISS;
          end
        end
        default: ;
      endcase
    end else begin
      if (cmd.mod_step) begin
        rem <= rem_next;
      end
      if (cmd.fetch) begin
        res_value  <= chars_rdata;
        res_status <= ST_DONE;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.value_out     <= res_value;
      out_data.status        <= res_status;
      out_data.alphabet_size <= 8'(count);
    end
  end

endmodule

FILE: sv/custom_alphabet_rotation_cipher.sv
// Rotation cipher over a programmable byte alphabet.
// Input channel (in_valid/in_ready/in_data): one transaction per item, kind
// clear, append or transform, plus a byte. Output channel (out_valid/
// out_ready/out_data): exactly one result transaction per input item, in order.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0
// rotation, index 1 direction; always ready, write only while the block is idle.
// Clear, append and transforms that need no table lookup go from acceptance
// straight to the result stage. A transform that looks up the alphabet first
// forms the bit-serial remainder of rotation by the alphabet size, one
// rotation bit per step, then forms the rotated index and reads the character
// memory (one registered port). The block takes no new item until the
// current item's result has moved to the output register.
// At reset the block runs a sweep that loads the default alphabet into the
// character and position memories; in_ready stays low meanwhile.
// A stalled receiver holds the result in the output register; the block
// still takes the next item, and that item's result waits inside until the
// output register frees up.
module custom_alphabet_rotation_cipher
  import cacr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cacr_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cacr_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cacr_cmd_t  cmd;
  cacr_stat_t stat;

  assign cfg_ready = 1'b1;

  cacr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cacr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: sv/cacr_checker.sv
module cacr_checker
  import cacr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input cacr_out_t out_data
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Accepting an item makes the block busy, so in_ready drops
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // A duplicate error drops the byte
  a_dup_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_DUP) |-> (out_data.value_out == 8'd0))
    else $error("duplicate error with nonzero byte");

  // Full status only at capacity
  a_full_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_FULL) |->
      (out_data.alphabet_size == 8'(ALPHABET_MAX)))
    else $error("full status below capacity");

endmodule

bind custom_alphabet_rotation_cipher cacr_checker u_cacr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
